// File: src/scalar_kalman_filter_unit_assert.svh
// Assertion macros for the scalar Kalman filter unit.
// Included by modules that check their own control logic; needs nothing else.
`ifndef SCALAR_KALMAN_FILTER_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication
`define SKF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/skf_pkg.sv
// Shared constants and register codes for the scalar Kalman filter unit.
// No dependencies.
package skf_pkg;

    localparam int SAMPLE_BITS_DEF        = 10;
    localparam int ESTIMATE_FRAC_BITS_DEF = 6;

    localparam int COV_W    = 32;
    localparam int EST_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int FACTOR_W = GAIN_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [COV_W-1:0] PROCESS_VARIANCE_RST = 32'd655;
    localparam logic [COV_W-1:0] SENSOR_VARIANCE_RST  = 32'd65536;
    localparam logic [COV_W-1:0] COVARIANCE_RST       = 32'd65536;
    localparam logic [FACTOR_W-1:0] GAIN_ONE          = 17'd65536;
    localparam logic [COV_W+1:0] ROUND_HALF           = 34'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_VARIANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_VARIANCE  = 2'd1;

endpackage

// File: src/scalar_kalman_filter_unit.sv
// Scalar Kalman filter unit: one sample in, one estimate and gain out.
// Depends on skf_pkg, skf_div, skf_mul and scalar_kalman_filter_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries sample and seed; an item is taken
//   when in_valid is high and in_stall low. Output channel (out_valid/out_stall)
//   carries estimate (Q10.6) and gain (Q0.16). Configuration writes go through
//   cfg_valid/cfg_ready with cfg_index and cfg_data: index 0 is the process
//   variance, index 1 the sensor variance, other indexes are ignored.
//   Path: a filtered item passes through the bit-serial gain divider, a step to
//   start the multipliers, two bit-serial multipliers running side by side
//   (covariance and estimate), a write-back step and the load of the output
//   register. A seeded item skips the divider and multipliers and goes straight
//   to the hand-over into the output register.
//   One item is in flight at a time; in_stall is high from acceptance until the
//   result has moved into the output register, so a new item is taken only after
//   the previous result is handed over. The output register lets the
//   next item start while a result still waits on out_stall; a held result
//   blocks only the hand-over. Reset: covariance 1.0, estimate zero, variances
//   at their reset values, no result pending.
module scalar_kalman_filter_unit
#(
    parameter int SAMPLE_BITS        = skf_pkg::SAMPLE_BITS_DEF,
    parameter int ESTIMATE_FRAC_BITS = skf_pkg::ESTIMATE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              seed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [skf_pkg::EST_W-1:0]         estimate,
    output logic [skf_pkg::GAIN_W-1:0]        gain,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [skf_pkg::COV_W-1:0]         cfg_data
);

    `include "scalar_kalman_filter_unit_assert.svh"

    localparam int COV_W  = skf_pkg::COV_W;
    localparam int EST_W  = skf_pkg::EST_W;
    localparam int GAIN_W = skf_pkg::GAIN_W;
    localparam int FAC_W  = skf_pkg::FACTOR_W;
    localparam int PROD_W = COV_W + FAC_W;
    localparam int ZW_W   = SAMPLE_BITS + EST_W;

    typedef enum logic [1:0] {S_IDLE, S_GAIN, S_MUL, S_DONE} state_t;

    state_t              state_reg;
    logic [COV_W-1:0]    pv_reg;
    logic [COV_W-1:0]    sv_reg;
    logic [COV_W-1:0]    p_reg;
    logic [EST_W-1:0]    x_reg;
    logic [EST_W-1:0]    z_reg;
    logic [COV_W-1:0]    pc_reg;
    logic [GAIN_W-1:0]   g_reg;
    logic                up_reg;
    logic                out_valid_reg;
    logic [EST_W-1:0]    est_out_reg;
    logic [GAIN_W-1:0]   gain_out_reg;

    logic                in_take;
    logic [ZW_W-1:0]     z_wide;
    logic [EST_W-1:0]    z_sat;
    logic [COV_W:0]      pc_sum;
    logic [COV_W-1:0]    pc_next;
    logic [COV_W:0]      den;

    logic                div_done;
    logic [GAIN_W-1:0]   div_q;
    logic                mul_start;
    logic                d_up;
    logic [EST_W-1:0]    d_mag;
    logic                cov_done;
    logic                est_done;
    logic [PROD_W-1:0]   cov_prod;
    logic [PROD_W-1:0]   est_prod;

    logic [COV_W+1:0]    adj_round;
    logic [EST_W+1:0]    adj;
    logic [EST_W+1:0]    x_up;
    logic [EST_W-1:0]    x_next;

    assign in_take = in_valid && !in_stall;

    assign z_wide = ZW_W'(sample) << ESTIMATE_FRAC_BITS;
    assign z_sat  = (|z_wide[ZW_W-1:EST_W]) ? '1 : z_wide[EST_W-1:0];

    assign pc_sum  = {1'b0, p_reg} + {1'b0, pv_reg};
    assign pc_next = pc_sum[COV_W] ? '1 : pc_sum[COV_W-1:0];
    assign den     = {1'b0, pc_next} + {1'b0, sv_reg};

    skf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take && !seed),
        .numer    (pc_next),
        .denom    (den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_start = (state_reg == S_GAIN) && div_done;
    assign d_up      = z_reg >= x_reg;
    assign d_mag     = d_up ? (z_reg - x_reg) : (x_reg - z_reg);

    skf_mul #(.A_W(COV_W), .B_W(FAC_W)) u_mul_cov
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (pc_reg),
        .b       (skf_pkg::GAIN_ONE - FAC_W'(div_q)),
        .done    (cov_done),
        .product (cov_prod)
    );

    skf_mul #(.A_W(COV_W), .B_W(FAC_W)) u_mul_est
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (COV_W'(d_mag)),
        .b       (FAC_W'(div_q)),
        .done    (est_done),
        .product (est_prod)
    );

    assign adj_round = est_prod[COV_W+1:0] + skf_pkg::ROUND_HALF;
    assign adj       = adj_round[COV_W+1:GAIN_W];
    assign x_up      = {2'b00, x_reg} + adj;

    always_comb
    begin
        if (up_reg)
        begin
            x_next = (|x_up[EST_W+1:EST_W]) ? '1 : x_up[EST_W-1:0];
        end
        else
        begin
            x_next = (adj > {2'b00, x_reg}) ? '0 : (x_reg - adj[EST_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= skf_pkg::PROCESS_VARIANCE_RST;
            sv_reg        <= skf_pkg::SENSOR_VARIANCE_RST;
            p_reg         <= skf_pkg::COVARIANCE_RST;
            x_reg         <= '0;
            z_reg         <= '0;
            pc_reg        <= '0;
            g_reg         <= '0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            est_out_reg   <= '0;
            gain_out_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    skf_pkg::CFG_PROCESS_VARIANCE: pv_reg <= cfg_data;
                    skf_pkg::CFG_SENSOR_VARIANCE:  sv_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        z_reg  <= z_sat;
                        pc_reg <= pc_next;
                        if (seed)
                        begin
                            x_reg     <= z_sat;
                            g_reg     <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_GAIN;
                        end
                    end
                end
                S_GAIN:
                begin
                    if (div_done)
                    begin
                        g_reg     <= div_q;
                        up_reg    <= d_up;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (cov_done && est_done)
                    begin
                        p_reg     <= cov_prod[COV_W+GAIN_W-1:GAIN_W];
                        x_reg     <= x_next;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        est_out_reg   <= x_reg;
                        gain_out_reg  <= g_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign gain      = gain_out_reg;

    `SKF_ASSERT_NOW(a_out_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == S_DONE), "result raised outside hand-over")
    `SKF_ASSERT_NOW(a_div_in_gain, clk, rst_n, div_done, state_reg == S_GAIN,
        "divider finished while not awaited")
    `SKF_ASSERT_NOW(a_mul_in_step, clk, rst_n, cov_done || est_done,
        state_reg == S_MUL && cov_done && est_done, "multipliers out of step")
    `SKF_ASSERT_NEXT(a_seed_path, clk, rst_n, in_take && seed,
        state_reg == S_DONE && g_reg == '0, "seeded item not passed straight through")

endmodule

// File: src/skf_div.sv
// Bit-serial restoring divider: gain = numer * 2^16 / denom, saturated.
// Uses skf_pkg for widths.
module skf_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [skf_pkg::COV_W-1:0]     numer,
    input  logic [skf_pkg::COV_W:0]       denom,
    output logic                          done,
    output logic [skf_pkg::GAIN_W-1:0]    quotient
);

    localparam int STEPS = skf_pkg::FACTOR_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = skf_pkg::COV_W + 2;

    logic [REM_W-1:0]              rem_reg;
    logic [skf_pkg::COV_W:0]       denom_reg;
    logic [skf_pkg::FACTOR_W-1:0]  q_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic                          ge;
    logic [REM_W-1:0]              trial;
    logic [REM_W-1:0]              rem_next;

    assign ge       = rem_reg >= {1'b0, denom_reg};
    assign trial    = rem_reg - {1'b0, denom_reg};
    assign rem_next = ge ? trial : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            denom_reg <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg   <= {2'b00, numer};
                denom_reg <= denom;
                q_reg     <= '0;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[skf_pkg::FACTOR_W-2:0], ge};
                rem_reg <= {rem_next[REM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[skf_pkg::FACTOR_W-1] ? '1 : q_reg[skf_pkg::GAIN_W-1:0];

endmodule

// File: src/skf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// No package dependencies.
module skf_mul
#(
    parameter int A_W = 32,
    parameter int B_W = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W-1:0]     a_reg;
    logic [B_W-1:0]     b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [A_W:0]       sum;

    assign sum = {1'b0, acc_reg[A_W+B_W-1:B_W]} + {1'b0, (b_reg[0] ? a_reg : '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= {sum, acc_reg[B_W-1:1]};
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
